// ----- src/tapm_pkg.sv -----
package tapm_pkg;

  localparam int unsigned THROTTLE_RESET = 1100;
  localparam int unsigned THROTTLE_MAX   = 4095;
  localparam logic [7:0]  CMD_UP         = 8'd49;
  localparam logic [7:0]  CMD_DOWN       = 8'd48;
  localparam logic [16:0] KEEP_Q16       = 17'd52429;
  localparam logic [19:0] TAKE_Q16       = 20'd939524;

  typedef enum logic [2:0] {
    REG_TILT_P = 3'd0,
    REG_TILT_I = 3'd1,
    REG_TILT_D = 3'd2,
    REG_TILT_L = 3'd3,
    REG_YAW_P  = 3'd4,
    REG_YAW_I  = 3'd5,
    REG_YAW_D  = 3'd6,
    REG_YAW_L  = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [15:0] p_gain;
    logic [15:0] i_gain;
    logic [15:0] d_gain;
    logic [9:0]  limit;
  } gains_t;

  // One strobe per pipeline step of the axis lanes.
  typedef struct packed {
    logic s0;
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } step_t;

endpackage

// ----- src/tapm_axis.sv -----
module tapm_axis
  import tapm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  step_t              step,
  input  gains_t             gains,
  input  logic signed [15:0] angle,
  input  logic signed [15:0] target,
  output logic signed [11:0] result
);

  logic signed [31:0] filt;
  logic signed [31:0] integ;
  logic signed [31:0] prev;

  logic signed [49:0] keep_prod;
  logic signed [36:0] take_prod;
  logic signed [15:0] target_q;
  logic signed [33:0] err;
  logic signed [50:0] prod_i;
  logic signed [50:0] prod_p;
  logic signed [51:0] prod_d;
  logic signed [52:0] pd_sum;

  logic signed [50:0] fsum;
  logic signed [34:0] f_new;
  logic signed [33:0] err_next;
  logic signed [34:0] derr;
  logic signed [35:0] isum;
  logic signed [35:0] ilim;
  logic signed [31:0] integ_next;
  logic signed [53:0] osum;
  logic signed [53:0] olim;
  logic signed [53:0] oclamp;
  logic signed [53:0] orounded;

  always_comb begin
    fsum     = 51'(keep_prod) + 51'(take_prod) + 51'sd32768;
    f_new    = 35'(fsum >>> 16);
    err_next = 34'(f_new) - (34'(target_q) <<< 12);
    derr     = 35'(err) - 35'(prev);
    ilim     = $signed({10'd0, gains.limit, 16'd0});
    isum     = 36'(integ) + 36'((prod_i + 51'sd32768) >>> 16);
    if (isum > ilim) begin
      integ_next = ilim[31:0];
    end else if (isum < -ilim) begin
      integ_next = 32'(-ilim);
    end else begin
      integ_next = isum[31:0];
    end
    olim = $signed({12'd0, gains.limit, 32'd0});
    osum = 54'(pd_sum) + (54'(integ) <<< 16);
    if (osum > olim) begin
      oclamp = olim;
    end else if (osum < -olim) begin
      oclamp = -olim;
    end else begin
      oclamp = osum;
    end
    orounded = (oclamp + 54'sd2147483648) >>> 32;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filt  <= '0;
      integ <= '0;
      prev  <= '0;
    end else begin
      if (step.s1) begin
        filt <= f_new[31:0];
      end
      if (step.s2) begin
        prev <= err[31:0];
      end
      if (step.s3) begin
        integ <= integ_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step.s0) begin
      keep_prod <= filt * $signed({1'b0, KEEP_Q16});
      take_prod <= angle * $signed({1'b0, TAKE_Q16});
      target_q  <= target;
    end
    if (step.s1) begin
      err <= err_next;
    end
    if (step.s2) begin
      prod_i <= $signed({1'b0, gains.i_gain}) * err;
      prod_p <= $signed({1'b0, gains.p_gain}) * err;
      prod_d <= $signed({1'b0, gains.d_gain}) * derr;
    end
    if (step.s3) begin
      pd_sum <= 53'(prod_p) + 53'(prod_d);
    end
    if (step.s4) begin
      result <= orounded[11:0];
    end
  end

endmodule

// ----- src/tapm_mix.sv -----
module tapm_mix
  import tapm_pkg::*;
#(
  parameter int DRIVE_WIDTH = 12
) (
  input  logic                   clk,
  input  logic                   load,
  input  logic [11:0]            throttle,
  input  logic signed [11:0]     roll,
  input  logic signed [11:0]     pitch,
  input  logic signed [11:0]     yaw,
  output logic [DRIVE_WIDTH-1:0] front_left_drive,
  output logic [DRIVE_WIDTH-1:0] front_right_drive,
  output logic [DRIVE_WIDTH-1:0] rear_left_drive,
  output logic [DRIVE_WIDTH-1:0] rear_right_drive,
  output logic [11:0]            throttle_level
);

  localparam logic signed [17:0] TOP = 18'sd1 <<< DRIVE_WIDTH;

  function automatic logic [DRIVE_WIDTH-1:0] sat(input logic signed [17:0] v);
    logic [DRIVE_WIDTH-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > TOP - 18'sd1) begin
      r = '1;
    end else begin
      r = v[DRIVE_WIDTH-1:0];
    end
    return r;
  endfunction

  logic signed [17:0] t, r, p, y;

  always_comb begin
    t = $signed({6'd0, throttle});
    r = 18'(roll);
    p = 18'(pitch);
    y = 18'(yaw);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      front_left_drive  <= sat(t - p - r + y);
      front_right_drive <= sat(t - p + r - y);
      rear_left_drive   <= sat(t + p - r - y);
      rear_right_drive  <= sat(t + p + r + y);
      throttle_level    <= throttle;
    end
  end

endmodule

// ----- src/three_axis_pid_motor_mixer_core.sv -----
// A result reaches the outputs once its accepted input transaction has passed
// the five-step multiply and clamp pipeline in each axis lane and the output
// register; no new input is taken while an item is in flight or a result is stalled.
// Reset (synchronous, active high) restores default gains and limits, sets the
// throttle to 1100 and clears the filter, integrator and error state.
module three_axis_pid_motor_mixer_core
  import tapm_pkg::*;
#(
  parameter int DRIVE_WIDTH = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             command_byte,
  input  logic signed [15:0]     yaw_angle,
  input  logic signed [15:0]     pitch_angle,
  input  logic signed [15:0]     roll_angle,
  input  logic signed [15:0]     roll_target,
  input  logic signed [15:0]     pitch_target,
  input  logic signed [15:0]     yaw_target,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DRIVE_WIDTH-1:0] front_left_drive,
  output logic [DRIVE_WIDTH-1:0] front_right_drive,
  output logic [DRIVE_WIDTH-1:0] rear_left_drive,
  output logic [DRIVE_WIDTH-1:0] rear_right_drive,
  output logic [11:0]            throttle_level,
  input  logic                   cfg_write,
  input  logic [2:0]             cfg_index,
  input  logic [15:0]            cfg_data
);

  gains_t tilt, yaw_g;
  logic [11:0] throttle;
  logic [4:0] pipe;
  logic accept;
  step_t step;
  logic signed [11:0] roll_res, pitch_res, yaw_res;

  assign in_stall = (|pipe) | (out_valid & out_stall);
  assign accept   = in_valid & ~in_stall;
  assign step     = '{s0: accept, s1: pipe[0], s2: pipe[1], s3: pipe[2], s4: pipe[3]};

  always_ff @(posedge clk) begin
    if (rst) begin
      tilt  <= '{p_gain: 16'd358, i_gain: 16'd512, d_gain: 16'd3840, limit: 10'd400};
      yaw_g <= '{p_gain: 16'd1024, i_gain: 16'd5, d_gain: 16'd0, limit: 10'd400};
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_TILT_P: tilt.p_gain  <= cfg_data;
        REG_TILT_I: tilt.i_gain  <= cfg_data;
        REG_TILT_D: tilt.d_gain  <= cfg_data;
        REG_TILT_L: tilt.limit   <= cfg_data[9:0];
        REG_YAW_P:  yaw_g.p_gain <= cfg_data;
        REG_YAW_I:  yaw_g.i_gain <= cfg_data;
        REG_YAW_D:  yaw_g.d_gain <= cfg_data;
        REG_YAW_L:  yaw_g.limit  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      throttle  <= 12'(THROTTLE_RESET);
      pipe      <= '0;
      out_valid <= 1'b0;
    end else begin
      pipe <= {pipe[3:0], accept};
      if (accept) begin
        if (command_byte == CMD_UP && throttle != 12'(THROTTLE_MAX)) begin
          throttle <= throttle + 12'd1;
        end else if (command_byte == CMD_DOWN && throttle != 12'd0) begin
          throttle <= throttle - 12'd1;
        end
      end
      if (pipe[4]) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  tapm_axis u_roll (
    .clk(clk), .rst(rst), .step(step), .gains(tilt),
    .angle(roll_angle), .target(roll_target), .result(roll_res)
  );

  tapm_axis u_pitch (
    .clk(clk), .rst(rst), .step(step), .gains(tilt),
    .angle(pitch_angle), .target(pitch_target), .result(pitch_res)
  );

  tapm_axis u_yaw (
    .clk(clk), .rst(rst), .step(step), .gains(yaw_g),
    .angle(yaw_angle), .target(yaw_target), .result(yaw_res)
  );

  tapm_mix #(.DRIVE_WIDTH(DRIVE_WIDTH)) u_mix (
    .clk(clk),
    .load(pipe[4]),
    .throttle(throttle),
    .roll(roll_res),
    .pitch(pitch_res),
    .yaw(yaw_res),
    .front_left_drive(front_left_drive),
    .front_right_drive(front_right_drive),
    .rear_left_drive(rear_left_drive),
    .rear_right_drive(rear_right_drive),
    .throttle_level(throttle_level)
  );

endmodule

// ----- tb/tb_top.sv -----
module tb_top
  import tapm_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0]         cmd;
    logic signed [15:0] yaw_a, pitch_a, roll_a;
    logic signed [15:0] roll_t, pitch_t, yaw_t;
  } sample_t;

  typedef struct {
    logic [11:0] fl, fr, rl, rr, thr;
  } drives_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0;
  logic in_stall, out_valid;
  logic [7:0] command_byte = '0;
  logic signed [15:0] yaw_angle = '0, pitch_angle = '0, roll_angle = '0;
  logic signed [15:0] roll_target = '0, pitch_target = '0, yaw_target = '0;
  logic [11:0] front_left_drive, front_right_drive, rear_left_drive, rear_right_drive;
  logic [11:0] throttle_level;
  logic cfg_write = 0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  three_axis_pid_motor_mixer_core uut (.*);

  initial forever #4 clk = ~clk;

  initial begin
    #20ms;
    $display("three_axis_pid_motor_mixer_core verification failed");
    $finish;
  end

  // Predictor state; index 0 roll, 1 pitch, 2 yaw.
  longint gp[3], gi[3], gd[3], glim[3];
  longint thr_q;
  longint filt[3], integ[3], prev_err[3];

  sample_t pending[$];
  drives_t motor_expect[$];
  int errors = 0, checked = 0;
  bit quiet = 0;   // long stretch with no idling
  bit hold = 0;

  function automatic longint round_sh(longint v, int k);
    return (v + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic longint clampl(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint pid_axis(int ax, longint angle, longint target, int g);
    longint f, e, s;
    f = round_sh(filt[ax] * 52429 + angle * 939524, 16);
    filt[ax] = longint'(int'(f));
    e = f - target * 4096;
    integ[ax] = clampl(integ[ax] + round_sh(gi[g] * e, 16), glim[g] * 65536);
    s = gp[g] * e + gd[g] * (e - prev_err[ax]) + integ[ax] * 65536;
    s = clampl(s, glim[g] * (longint'(1) <<< 32));
    prev_err[ax] = longint'(int'(e));
    return round_sh(s, 32);
  endfunction

  function automatic logic [11:0] sat12(longint v);
    if (v < 0) return 12'd0;
    if (v > 4095) return 12'hFFF;
    return v[11:0];
  endfunction

  function automatic drives_t mix_motors(sample_t s);
    drives_t d;
    longint r, p, y, t;
    if (s.cmd == CMD_UP && thr_q < THROTTLE_MAX) thr_q++;
    else if (s.cmd == CMD_DOWN && thr_q > 0) thr_q--;
    r = pid_axis(0, s.roll_a, s.roll_t, 0);
    p = pid_axis(1, s.pitch_a, s.pitch_t, 1);
    y = pid_axis(2, s.yaw_a, s.yaw_t, 2);
    t = thr_q;
    d.fl = sat12(t - p - r + y);
    d.fr = sat12(t - p + r - y);
    d.rl = sat12(t + p - r - y);
    d.rr = sat12(t + p + r + y);
    d.thr = t[11:0];
    return d;
  endfunction

  task automatic write_reg(reg_index_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 0;
    case (idx)
      REG_TILT_P: begin gp[0] = val; gp[1] = val; end
      REG_TILT_I: begin gi[0] = val; gi[1] = val; end
      REG_TILT_D: begin gd[0] = val; gd[1] = val; end
      REG_TILT_L: begin glim[0] = val[9:0]; glim[1] = val[9:0]; end
      REG_YAW_P:  gp[2] = val;
      REG_YAW_I:  gi[2] = val;
      REG_YAW_D:  gd[2] = val;
      REG_YAW_L:  glim[2] = val[9:0];
    endcase
  endtask

  task automatic drain();
    while (pending.size() != 0 || motor_expect.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic sample_t rand_sample(bit tame);
    sample_t s;
    int pick;
    pick = $urandom_range(0, 9);
    s.cmd = pick < 4 ? CMD_UP : pick < 7 ? CMD_DOWN : 8'($urandom);
    if (tame) begin
      s.yaw_a = 16'($signed($urandom_range(0, 1600)) - 800);
      s.pitch_a = 16'($signed($urandom_range(0, 1600)) - 800);
      s.roll_a = 16'($signed($urandom_range(0, 1600)) - 800);
      s.roll_t = 16'($signed($urandom_range(0, 40)) - 20);
      s.pitch_t = 16'($signed($urandom_range(0, 40)) - 20);
      s.yaw_t = 16'($signed($urandom_range(0, 40)) - 20);
    end else begin
      s.yaw_a = 16'($urandom); s.pitch_a = 16'($urandom); s.roll_a = 16'($urandom);
      s.roll_t = 16'($urandom); s.pitch_t = 16'($urandom); s.yaw_t = 16'($urandom);
    end
    return s;
  endfunction

  // Driver: presents the oldest pending item and holds it while stalled.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        motor_expect.push_back(mix_motors(pending.pop_front()));
      end
      if (!(in_valid && in_stall)) begin
        if (pending.size() != 0 && !hold && (quiet || $urandom_range(0, 99) >= 35)) begin
          in_valid <= 1;
          command_byte <= pending[0].cmd;
          yaw_angle <= pending[0].yaw_a;
          pitch_angle <= pending[0].pitch_a;
          roll_angle <= pending[0].roll_a;
          roll_target <= pending[0].roll_t;
          pitch_target <= pending[0].pitch_t;
          yaw_target <= pending[0].yaw_t;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (motor_expect.size() == 0) begin
          $display("%0t: unexpected result fl=%0d fr=%0d rl=%0d rr=%0d thr=%0d", $time,
                   front_left_drive, front_right_drive, rear_left_drive,
                   rear_right_drive, throttle_level);
          errors++;
        end else begin
          drives_t d;
          d = motor_expect.pop_front();
          checked++;
          if (d.fl !== front_left_drive || d.fr !== front_right_drive ||
              d.rl !== rear_left_drive || d.rr !== rear_right_drive ||
              d.thr !== throttle_level) begin
            $display("%0t: expected fl=%0d fr=%0d rl=%0d rr=%0d thr=%0d", $time,
                     d.fl, d.fr, d.rl, d.rr, d.thr);
            $display("%0t:   actual fl=%0d fr=%0d rl=%0d rr=%0d thr=%0d", $time,
                     front_left_drive, front_right_drive, rear_left_drive,
                     rear_right_drive, throttle_level);
            errors++;
          end
        end
      end
      out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 35);
    end
  end

  initial begin
    sample_t s;
    int phase;
    gp = '{358, 358, 1024}; gi = '{512, 512, 5}; gd = '{3840, 3840, 0};
    glim = '{400, 400, 400};
    thr_q = THROTTLE_RESET;
    filt = '{0, 0, 0}; integ = '{0, 0, 0}; prev_err = '{0, 0, 0};
    repeat (9) @(posedge clk);
    rst <= 0;

    // Directed: field extremes and each command.
    s = '{CMD_UP, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
    pending.push_back(s);
    s = '{CMD_DOWN, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000};
    pending.push_back(s);
    s = '{8'hFF, '0, '0, '0, '0, '0, '0};
    pending.push_back(s);
    s = '{8'h00, 16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000};
    pending.push_back(s);
    s = '{8'hAA, -16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh7FFF};
    pending.push_back(s);
    drain();

    // Walk the throttle to the bottom end and try going below it.
    hold = 1;
    for (int k = 0; k < 700; k++) begin
      s = rand_sample($urandom_range(0, 3) != 0);
      s.cmd = CMD_DOWN;
      pending.push_back(s);
    end
    hold = 0;
    // The sequence waits until every result is in.
    drain();

    // The rest of the walk runs with no idling on either side.
    quiet = 1;
    for (int k = 0; k < 410; k++) begin
      s = rand_sample($urandom_range(0, 3) != 0);
      s.cmd = CMD_DOWN;
      pending.push_back(s);
    end
    drain();
    quiet = 0;

    // Zero limits, then extremes of gains, then the defaults, then random settings.
    write_reg(REG_TILT_L, 16'd0);
    write_reg(REG_YAW_L, 16'd0);
    for (int k = 0; k < 8; k++) pending.push_back(rand_sample(0));
    drain();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_TILT_P, 16'hFFFF); write_reg(REG_TILT_I, 16'hFFFF);
          write_reg(REG_TILT_D, 16'hFFFF); write_reg(REG_TILT_L, 16'd1000);
          write_reg(REG_YAW_P, 16'hFFFF); write_reg(REG_YAW_I, 16'hFFFF);
          write_reg(REG_YAW_D, 16'hFFFF); write_reg(REG_YAW_L, 16'd1000);
        end
        1: begin
          write_reg(REG_TILT_P, 16'd0); write_reg(REG_TILT_I, 16'd0);
          write_reg(REG_TILT_D, 16'd0); write_reg(REG_TILT_L, 16'h03FF);
          write_reg(REG_YAW_P, 16'd0); write_reg(REG_YAW_I, 16'd0);
          write_reg(REG_YAW_D, 16'd0); write_reg(REG_YAW_L, 16'd1);
        end
        2: begin
          write_reg(REG_TILT_P, 16'd358); write_reg(REG_TILT_I, 16'd512);
          write_reg(REG_TILT_D, 16'd3840); write_reg(REG_TILT_L, 16'd400);
          write_reg(REG_YAW_P, 16'd1024); write_reg(REG_YAW_I, 16'd5);
          write_reg(REG_YAW_D, 16'd0); write_reg(REG_YAW_L, 16'd400);
        end
        3: begin
          for (int r = 0; r < 8; r++) write_reg(reg_index_t'(r), 16'($urandom));
        end
      endcase
      for (int k = 0; k < 32; k++) pending.push_back(rand_sample($urandom_range(0, 3) != 0));
      drain();
    end

    if (motor_expect.size() != 0) errors++;
    $display("Checked %0d motor results over directed extremes, throttle floor,", checked);
    $display("zero limits and four gain settings with random stalls.");
    if (errors == 0) begin
      $display("three_axis_pid_motor_mixer_core verification clean");
    end else begin
      $display("three_axis_pid_motor_mixer_core verification failed");
    end
    $finish;
  end
endmodule
